/* hdl/euler_to_rotation_matrix_core_macros.svh */
// Assertion macros for the Euler-to-rotation-matrix RTL.
// Depends on nothing; included by e2r_matmul, the module that carries assertions.
`ifndef EULER_TO_ROTATION_MATRIX_CORE_MACROS_SVH
`define EULER_TO_ROTATION_MATRIX_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define E2R_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define E2R_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/e2r_pkg.sv */
// Shared constants, types and tables for the Euler-to-rotation-matrix core.
// Depends on nothing; imported by every other file of the block but the macro header.
package e2r_pkg;

    localparam int ANGLE_BITS      = 24;
    localparam int ENTRY_FRAC_BITS = 16;
    localparam int ENTRY_BITS      = ENTRY_FRAC_BITS + 2;
    localparam int WORK_FRAC       = 30;
    localparam int CW              = WORK_FRAC + 3;
    localparam int PW              = 2 * CW;
    localparam int CORDIC_ITERS    = 30;
    localparam int DEG_HALF_TURN   = 180;

    // Angle to phase scale factors: 2^65/pi and round(2^63/180).
    localparam logic [63:0] RAD_TO_TURN = 64'hA2F9836E4E441529;
    localparam logic [63:0] DEG_TO_TURN =
        ((64'd1 << 63) + 64'(DEG_HALF_TURN / 2)) / 64'(DEG_HALF_TURN);
    localparam int RAD_SHIFT = ANGLE_BITS - 2;
    localparam int DEG_SHIFT = ANGLE_BITS - 10;

    localparam logic signed [CW-1:0] CORDIC_GAIN = CW'(652032874);
    localparam logic signed [CW-1:0] ONE_WORK    = CW'(1) << WORK_FRAC;

    localparam logic [31:0] ATAN_TURNS [CORDIC_ITERS] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
        32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
        32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
        32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
        32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1
    };

    // Register indexes on the configuration port.
    localparam logic REG_ORDER   = 1'b0;
    localparam logic REG_RADIANS = 1'b1;

    typedef enum logic [2:0] {
        ORD_XYZ = 3'd0,
        ORD_XZY = 3'd1,
        ORD_YXZ = 3'd2,
        ORD_ZXY = 3'd3,
        ORD_ZYX = 3'd4,
        ORD_YZX = 3'd5
    } t_order;

    typedef struct packed {
        logic [2:0] order;
        logic       radians;
    } t_cfg;

    typedef logic signed [CW-1:0]         t_work;
    typedef logic signed [PW-1:0]         t_prod;
    typedef logic signed [ENTRY_BITS-1:0] t_entry;
    typedef logic [ANGLE_BITS-1:0]        t_angle;

    // One CORDIC lane: quadrant, vector and residual phase.
    typedef struct packed {
        logic [1:0]  quad;
        t_work       x;
        t_work       y;
        logic signed [31:0] z;
    } t_lane;

endpackage

/* hdl/e2r_if.sv */
// Stream interfaces for the pose request and the matrix result.
// Depends on e2r_pkg for the field types.
interface e2r_in_if import e2r_pkg::*; ();
    logic   valid;
    logic   ready;
    t_angle angle_x;
    t_angle angle_y;
    t_angle angle_z;

    modport source (output valid, angle_x, angle_y, angle_z, input ready);
    modport sink   (input valid, angle_x, angle_y, angle_z, output ready);
endinterface

interface e2r_out_if import e2r_pkg::*; ();
    logic   valid;
    logic   ready;
    t_entry r00, r01, r02, r10, r11, r12, r20, r21, r22;

    modport source (output valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
                    input ready);
    modport sink   (input valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
                    output ready);
endinterface

/* hdl/e2r_phase.sv */
// Angle to turn-phase conversion, four pipeline stages, three lanes.
// Depends on e2r_pkg; feeds e2r_cordic.
module e2r_phase import e2r_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_cfg   i_cfg,
    input  logic   i_valid,
    output logic   o_ready,
    input  t_angle i_angle [3],
    output logic   o_valid,
    input  logic   i_ready,
    output t_lane  o_lane [3]
);
    localparam int NS = 4;

    logic          r_v [NS];
    logic          en  [NS];
    t_angle        r_mag [3];
    logic          r_neg0 [3];
    logic [ANGLE_BITS+31:0] r_lo [3];
    logic [ANGLE_BITS+31:0] r_hi [3];
    logic          r_neg1 [3];
    logic [31:0]   r_ph [3];
    logic          r_neg2 [3];
    t_lane         r_lane [3];

    t_angle        n_mag [3];
    logic [ANGLE_BITS+31:0] n_lo [3];
    logic [ANGLE_BITS+31:0] n_hi [3];
    logic [31:0]   n_ph [3];
    t_lane         n_lane [3];

    // A stage loads when it is empty or its successor loads.
    always_comb begin
        en[NS-1] = !r_v[NS-1] || i_ready;
        for (int k = NS - 2; k >= 0; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    assign o_ready = en[0];
    assign o_valid = r_v[NS-1];
    assign o_lane  = r_lane;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NS; k++) r_v[k] <= 1'b0;
        end else begin
            for (int k = 0; k < NS; k++) begin
                if (en[k]) r_v[k] <= (k == 0) ? i_valid : r_v[k-1];
            end
        end
    end

    // Datapath of the four stages.
    always_comb begin
        logic [63:0]            c_sel;
        logic [ANGLE_BITS+32:0] sum;
        logic [31:0]            ph_s;
        logic [31:0]            ph_r;
        logic [1:0]             q;
        logic [31:0]            d;
        c_sel = i_cfg.radians ? RAD_TO_TURN : DEG_TO_TURN;
        for (int a = 0; a < 3; a++) begin
            // Magnitude; the most negative code maps onto itself.
            n_mag[a] = i_angle[a][ANGLE_BITS-1] ? (~i_angle[a] + 1'b1) : i_angle[a];
            // Split product against the 64-bit constant.
            n_lo[a] = (ANGLE_BITS+32)'(r_mag[a]) * (ANGLE_BITS+32)'(c_sel[31:0]);
            n_hi[a] = (ANGLE_BITS+32)'(r_mag[a]) * (ANGLE_BITS+32)'(c_sel[63:32]);
            sum = (ANGLE_BITS+33)'(r_hi[a]) + (ANGLE_BITS+33)'(r_lo[a] >> 32);
            n_ph[a] = i_cfg.radians ? 32'(sum >> RAD_SHIFT) : 32'(sum >> DEG_SHIFT);
            // Sign, nearest quadrant and residual phase.
            ph_s = r_neg2[a] ? (32'd0 - r_ph[a]) : r_ph[a];
            ph_r = ph_s + 32'h2000_0000;
            q    = ph_r[31:30];
            d    = ph_s - {q, 30'd0};
            n_lane[a].quad = q;
            n_lane[a].x    = CORDIC_GAIN;
            n_lane[a].y    = '0;
            n_lane[a].z    = signed'(d);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int a = 0; a < 3; a++) begin
            if (en[0]) begin
                r_mag[a]  <= n_mag[a];
                r_neg0[a] <= i_angle[a][ANGLE_BITS-1];
            end
            if (en[1]) begin
                r_lo[a]   <= n_lo[a];
                r_hi[a]   <= n_hi[a];
                r_neg1[a] <= r_neg0[a];
            end
            if (en[2]) begin
                r_ph[a]   <= n_ph[a];
                r_neg2[a] <= r_neg1[a];
            end
            if (en[3]) r_lane[a] <= n_lane[a];
        end
    end

endmodule

/* hdl/e2r_cordic.sv */
// Rotation-mode CORDIC, one iteration per pipeline stage, three lanes.
// Depends on e2r_pkg; fed by e2r_phase, feeds e2r_matmul.
module e2r_cordic import e2r_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_lane i_lane [3],
    output logic  o_valid,
    input  logic  i_ready,
    output t_lane o_lane [3]
);
    localparam int NS = CORDIC_ITERS;

    logic  r_v [NS];
    logic  en  [NS];
    t_lane r_lane [NS][3];
    t_lane stg_in [NS][3];
    t_lane n_lane [NS][3];

    always_comb begin
        en[NS-1] = !r_v[NS-1] || i_ready;
        for (int k = NS - 2; k >= 0; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    assign o_ready = en[0];
    assign o_valid = r_v[NS-1];
    assign o_lane  = r_lane[NS-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NS; k++) r_v[k] <= 1'b0;
        end else begin
            for (int k = 0; k < NS; k++) begin
                if (en[k]) r_v[k] <= (k == 0) ? i_valid : r_v[k-1];
            end
        end
    end

    // Stage k rotates by atan(2^-k) toward zero residual phase.
    always_comb begin
        t_work xs;
        t_work ys;
        stg_in[0] = i_lane;
        for (int k = 1; k < NS; k++) stg_in[k] = r_lane[k-1];
        for (int k = 0; k < NS; k++) begin
            for (int a = 0; a < 3; a++) begin
                xs = stg_in[k][a].x >>> k;
                ys = stg_in[k][a].y >>> k;
                n_lane[k][a].quad = stg_in[k][a].quad;
                if (!stg_in[k][a].z[31]) begin
                    n_lane[k][a].x = stg_in[k][a].x - ys;
                    n_lane[k][a].y = stg_in[k][a].y + xs;
                    n_lane[k][a].z = stg_in[k][a].z - signed'(ATAN_TURNS[k]);
                end else begin
                    n_lane[k][a].x = stg_in[k][a].x + ys;
                    n_lane[k][a].y = stg_in[k][a].y - xs;
                    n_lane[k][a].z = stg_in[k][a].z + signed'(ATAN_TURNS[k]);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NS; k++) begin
            if (en[k]) r_lane[k] <= n_lane[k];
        end
    end

endmodule

/* hdl/e2r_matmul.sv */
// Builds the three elementary rotations and multiplies them in the selected
// order, then rounds and clamps to output format. Depends on e2r_pkg and the macro header.
`include "euler_to_rotation_matrix_core_macros.svh"
module e2r_matmul import e2r_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_cfg   i_cfg,
    input  logic   i_valid,
    output logic   o_ready,
    input  t_lane  i_lane [3],
    output logic   o_valid,
    input  logic   i_ready,
    output t_entry o_ent [9]
);
    localparam int NS        = 6;
    localparam int RND_SHIFT = WORK_FRAC - ENTRY_FRAC_BITS;
    localparam logic signed [CW-1:0] RND_HALF =
        (RND_SHIFT == 0) ? CW'(0) : (CW'(1) << ((RND_SHIFT == 0) ? 0 : RND_SHIFT - 1));
    localparam logic signed [CW-1:0] ENT_LIM = CW'(1) << ENTRY_FRAC_BITS;

    logic   r_v [NS];
    logic   en  [NS];
    t_work  r_a  [3][3];
    t_work  r_b  [3][3];
    t_work  r_c0 [3][3];
    t_prod  r_p1 [3][3][3];
    t_work  r_c1 [3][3];
    t_work  r_t  [3][3];
    t_work  r_c2 [3][3];
    t_prod  r_p2 [3][3][3];
    t_work  r_res [3][3];
    t_entry r_ent [9];

    t_work  rot   [3][3][3];
    t_work  n_a   [3][3];
    t_work  n_b   [3][3];
    t_work  n_c   [3][3];
    t_prod  n_p1  [3][3][3];
    t_work  n_t   [3][3];
    t_prod  n_p2  [3][3][3];
    t_work  n_res [3][3];
    t_entry n_ent [9];
    logic   ent_ok;

    always_comb begin
        en[NS-1] = !r_v[NS-1] || i_ready;
        for (int k = NS - 2; k >= 0; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    assign o_ready = en[0];
    assign o_valid = r_v[NS-1];
    assign o_ent   = r_ent;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NS; k++) r_v[k] <= 1'b0;
        end else begin
            for (int k = 0; k < NS; k++) begin
                if (en[k]) r_v[k] <= (k == 0) ? i_valid : r_v[k-1];
            end
        end
    end

    // Quadrant fold and elementary rotations, then order selection.
    always_comb begin
        t_work      cs [3];
        t_work      sn [3];
        logic [1:0] ia;
        logic [1:0] ib;
        logic [1:0] ic;
        for (int a = 0; a < 3; a++) begin
            unique case (i_lane[a].quad)
                2'd0: begin cs[a] = i_lane[a].x;  sn[a] = i_lane[a].y;  end
                2'd1: begin cs[a] = -i_lane[a].y; sn[a] = i_lane[a].x;  end
                2'd2: begin cs[a] = -i_lane[a].x; sn[a] = -i_lane[a].y; end
                default: begin cs[a] = i_lane[a].y; sn[a] = -i_lane[a].x; end
            endcase
        end
        for (int a = 0; a < 3; a++)
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++) rot[a][i][j] = '0;
        rot[0][0][0] = ONE_WORK;
        rot[0][1][1] = cs[0]; rot[0][1][2] = -sn[0];
        rot[0][2][1] = sn[0]; rot[0][2][2] = cs[0];
        rot[1][1][1] = ONE_WORK;
        rot[1][0][0] = cs[1]; rot[1][0][2] = sn[1];
        rot[1][2][0] = -sn[1]; rot[1][2][2] = cs[1];
        rot[2][2][2] = ONE_WORK;
        rot[2][0][0] = cs[2]; rot[2][0][1] = -sn[2];
        rot[2][1][0] = sn[2]; rot[2][1][1] = cs[2];
        unique case (t_order'(i_cfg.order))
            ORD_XYZ: begin ia = 2'd0; ib = 2'd1; ic = 2'd2; end
            ORD_XZY: begin ia = 2'd0; ib = 2'd2; ic = 2'd1; end
            ORD_YXZ: begin ia = 2'd1; ib = 2'd0; ic = 2'd2; end
            ORD_ZXY: begin ia = 2'd2; ib = 2'd0; ic = 2'd1; end
            ORD_ZYX: begin ia = 2'd2; ib = 2'd1; ic = 2'd0; end
            ORD_YZX: begin ia = 2'd1; ib = 2'd2; ic = 2'd0; end
            default: begin ia = 2'd0; ib = 2'd1; ic = 2'd2; end
        endcase
        n_a = rot[ia];
        n_b = rot[ib];
        n_c = rot[ic];
    end

    // Products, sums with floor back to Q30, and output rounding.
    always_comb begin
        logic signed [PW+1:0] acc;
        t_work                rr;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                for (int k = 0; k < 3; k++) begin
                    n_p1[i][j][k] = t_prod'(r_a[i][k]) * t_prod'(r_b[k][j]);
                    n_p2[i][j][k] = t_prod'(r_t[i][k]) * t_prod'(r_c2[k][j]);
                end
                acc = (PW+2)'(r_p1[i][j][0]) + (PW+2)'(r_p1[i][j][1])
                    + (PW+2)'(r_p1[i][j][2]);
                n_t[i][j] = CW'(acc >>> WORK_FRAC);
                acc = (PW+2)'(r_p2[i][j][0]) + (PW+2)'(r_p2[i][j][1])
                    + (PW+2)'(r_p2[i][j][2]);
                n_res[i][j] = CW'(acc >>> WORK_FRAC);
                rr = (r_res[i][j] + RND_HALF) >>> RND_SHIFT;
                if (rr > ENT_LIM) begin
                    rr = ENT_LIM;
                end else if (rr < -ENT_LIM) begin
                    rr = -ENT_LIM;
                end
                n_ent[i*3+j] = ENTRY_BITS'(rr);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_a  <= n_a;
            r_b  <= n_b;
            r_c0 <= n_c;
        end
        if (en[1]) begin
            r_p1 <= n_p1;
            r_c1 <= r_c0;
        end
        if (en[2]) begin
            r_t  <= n_t;
            r_c2 <= r_c1;
        end
        if (en[3]) r_p2  <= n_p2;
        if (en[4]) r_res <= n_res;
        if (en[5]) r_ent <= n_ent;
    end

    // Every delivered entry lies within plus or minus one.
    always_comb begin
        ent_ok = 1'b1;
        for (int e = 0; e < 9; e++) begin
            if (r_ent[e] > ENTRY_BITS'(ENT_LIM) || r_ent[e] < -ENTRY_BITS'(ENT_LIM))
                ent_ok = 1'b0;
        end
    end

    `E2R_ASSERT_NOW(a_ent_range, i_clk, i_rst_n, r_v[NS-1], ent_ok, "entry out of range")
    `E2R_ASSERT_NEXT(a_mid_hold, i_clk, i_rst_n, r_v[2] && !en[3], r_v[2], "stalled item lost")
    `E2R_ASSERT_NOW(a_bubble_rdy, i_clk, i_rst_n, !r_v[0], o_ready, "empty stage not ready")

endmodule

/* hdl/euler_to_rotation_matrix_core.sv */
// Top level of the Euler-angle to rotation-matrix core: register port and pipeline.
// Depends on e2r_pkg, e2r_if, e2r_phase, e2r_cordic and e2r_matmul.
//
//  Channel  Dir  Payload                         Handshake
//  i_pose   in   angle_x, angle_y, angle_z       valid/ready
//  o_mat    out  r00 .. r22, signed Q1.16        valid/ready
//  APB      in   rotation_order, angles_in_rad.  psel/penable, pready=1
//
// One request is taken per cycle while the first stage can load; a request
// passes 4 phase stages, 30 CORDIC stages and 6 matrix stages.
// Every stage holds a valid bit; an empty stage loads even while later ones stall.
// Reset (synchronous, active low) empties the pipeline and sets
// rotation_order to 0 and angles_in_radians to 1.
module euler_to_rotation_matrix_core import e2r_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    e2r_in_if.sink      i_pose,
    e2r_out_if.source   o_mat,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    logic [2:0] r_order;
    logic       r_radians;
    t_cfg       cfg;
    t_angle     angles [3];
    logic       ph_valid, ph_ready;
    t_lane      ph_lane [3];
    logic       cd_valid, cd_ready;
    t_lane      cd_lane [3];
    t_entry     ent [9];

    // Configuration registers.
    assign pready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_order   <= 3'd0;
            r_radians <= 1'b1;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[2])
                REG_ORDER:   r_order   <= pwdata[2:0];
                REG_RADIANS: r_radians <= pwdata[0];
                default:     ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_ORDER:   prdata = {29'd0, r_order};
            REG_RADIANS: prdata = {31'd0, r_radians};
            default:     prdata = '0;
        endcase
    end

    assign cfg.order   = r_order;
    assign cfg.radians = r_radians;

    assign angles[0] = i_pose.angle_x;
    assign angles[1] = i_pose.angle_y;
    assign angles[2] = i_pose.angle_z;

    // Pipeline sections.
    e2r_phase u_phase (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_valid (i_pose.valid),
        .o_ready (i_pose.ready),
        .i_angle (angles),
        .o_valid (ph_valid),
        .i_ready (ph_ready),
        .o_lane  (ph_lane)
    );

    e2r_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (ph_valid),
        .o_ready (ph_ready),
        .i_lane  (ph_lane),
        .o_valid (cd_valid),
        .i_ready (cd_ready),
        .o_lane  (cd_lane)
    );

    e2r_matmul u_matmul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_valid (cd_valid),
        .o_ready (cd_ready),
        .i_lane  (cd_lane),
        .o_valid (o_mat.valid),
        .i_ready (o_mat.ready),
        .o_ent   (ent)
    );

    assign o_mat.r00 = ent[0];
    assign o_mat.r01 = ent[1];
    assign o_mat.r02 = ent[2];
    assign o_mat.r10 = ent[3];
    assign o_mat.r11 = ent[4];
    assign o_mat.r12 = ent[5];
    assign o_mat.r20 = ent[6];
    assign o_mat.r21 = ent[7];
    assign o_mat.r22 = ent[8];

endmodule

/* sim/e2r_tb_checker.sv */
// Checker for the Euler-angle to rotation-matrix core: predicts each matrix
// from the accepted pose requests and compares it with the output channel.
// Depends on e2r_pkg and the stream interfaces in e2r_if.
module e2r_tb_checker import e2r_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [2:0] i_order,
    input  logic       i_radians,
    e2r_in_if          pose,
    e2r_out_if         mat,
    output int         o_fail_count,
    output int         o_matrix_count,
    output int         o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic signed [63:0] t_q30;
    typedef t_q30 t_mat [3][3];
    typedef struct {
        t_entry e [9];
    } t_matrix;

    t_matrix expected_matrices[$];

    assign o_pending = expected_matrices.size();

    // Floor division by a power of two.
    function automatic t_q30 floor_shift(t_q30 v, int n);
        return v >>> n;
    endfunction

    // Angle in request units to a 32-bit phase of one turn.
    function automatic logic [31:0] phase_of(t_angle raw, logic rad);
        logic        neg;
        logic [63:0] mag;
        logic [63:0] k;
        logic [127:0] prod;
        logic [31:0] ph;
        neg  = raw[ANGLE_BITS-1];
        mag  = neg ? 64'(t_angle'(~raw + 1'b1)) : 64'(raw);
        if (neg && mag == 0) mag = 64'd1 << (ANGLE_BITS - 1);
        k    = rad ? RAD_TO_TURN : DEG_TO_TURN;
        prod = mag * k;
        ph   = rad ? 32'(prod >> (30 + ANGLE_BITS)) : 32'(prod >> (22 + ANGLE_BITS));
        return neg ? 32'(0) - ph : ph;
    endfunction

    // Rotation-based cosine and sine in Q30, with quadrant folding.
    function automatic void cos_sin(input logic [31:0] ph, output t_q30 c,
                                    output t_q30 s);
        logic [1:0]  q;
        logic [31:0] d;
        t_q30 x, y, z, xs, ys;
        q = 2'((ph + 32'h2000_0000) >> 30);
        d = ph - ({30'd0, q} << 30);
        z = 64'(signed'(d));
        x = 652032874;
        y = 0;
        for (int i = 0; i < CORDIC_ITERS; i++) begin
            xs = floor_shift(x, i);
            ys = floor_shift(y, i);
            if (z >= 0) begin
                x = x - ys; y = y + xs; z = z - 64'(ATAN_TURNS[i]);
            end else begin
                x = x + ys; y = y - xs; z = z + 64'(ATAN_TURNS[i]);
            end
        end
        case (q)
            2'd0: begin c = x;  s = y;  end
            2'd1: begin c = -y; s = x;  end
            2'd2: begin c = -x; s = -y; end
            default: begin c = y; s = -x; end
        endcase
    endfunction

    function automatic t_mat mat_product(t_mat a, t_mat b);
        t_mat r;
        t_q30 acc;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++) begin
                acc = 0;
                for (int k = 0; k < 3; k++) acc = acc + a[i][k] * b[k][j];
                r[i][j] = floor_shift(acc, 30);
            end
        return r;
    endfunction

    // Full prediction of the matrix for one pose request.
    function automatic t_matrix rotation_matrix(t_angle ax, t_angle ay, t_angle az,
                                                logic [2:0] ord, logic rad);
        t_mat rx, ry, rz, m1, m2, m3, tmp, res;
        t_q30 c, s, lim, v;
        t_matrix out;
        lim = 64'sd1 <<< ENTRY_FRAC_BITS;
        foreach (rx[i, j]) begin
            rx[i][j] = 0; ry[i][j] = 0; rz[i][j] = 0;
        end
        cos_sin(phase_of(ax, rad), c, s);
        rx[0][0] = 64'sd1 <<< 30; rx[1][1] = c; rx[1][2] = -s; rx[2][1] = s; rx[2][2] = c;
        cos_sin(phase_of(ay, rad), c, s);
        ry[1][1] = 64'sd1 <<< 30; ry[0][0] = c; ry[0][2] = s; ry[2][0] = -s; ry[2][2] = c;
        cos_sin(phase_of(az, rad), c, s);
        rz[2][2] = 64'sd1 <<< 30; rz[0][0] = c; rz[0][1] = -s; rz[1][0] = s; rz[1][1] = c;
        case (ord)
            ORD_XZY: begin m1 = rx; m2 = rz; m3 = ry; end
            ORD_YXZ: begin m1 = ry; m2 = rx; m3 = rz; end
            ORD_ZXY: begin m1 = rz; m2 = rx; m3 = ry; end
            ORD_ZYX: begin m1 = rz; m2 = ry; m3 = rx; end
            ORD_YZX: begin m1 = ry; m2 = rz; m3 = rx; end
            // Unused codes behave like X*Y*Z.
            default: begin m1 = rx; m2 = ry; m3 = rz; end
        endcase
        tmp = mat_product(m1, m2);
        res = mat_product(tmp, m3);
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++) begin
                v = floor_shift(res[i][j] + (64'sd1 <<< (29 - ENTRY_FRAC_BITS)),
                                30 - ENTRY_FRAC_BITS);
                if (v > lim) v = lim;
                if (v < -lim) v = -lim;
                out.e[i*3+j] = t_entry'(v);
            end
        return out;
    endfunction

    // Append one predicted matrix at the tail of the expectation queue.
    task automatic enqueue_expected(input t_matrix m);
        expected_matrices.insert(expected_matrices.size(), m);
    endtask

    task automatic report_mismatch(input string what);
        $display("[%0t] matrix mismatch: %s", $realtime, what);
        o_fail_count++;
    endtask

    // Predict on accepted requests, compare on accepted matrices.
    always @(posedge i_clk) begin
        t_matrix got, want;
        if (!i_rst_n) begin
            expected_matrices.delete();
            o_fail_count   = 0;
            o_matrix_count = 0;
        end else begin
            if (pose.valid && pose.ready)
                enqueue_expected(rotation_matrix(pose.angle_x, pose.angle_y,
                                 pose.angle_z, i_order, i_radians));
            if (mat.valid && mat.ready) begin
                got.e = '{mat.r00, mat.r01, mat.r02, mat.r10, mat.r11, mat.r12,
                          mat.r20, mat.r21, mat.r22};
                o_matrix_count++;
                if (expected_matrices.size() == 0) begin
                    report_mismatch("matrix with no request outstanding");
                end else begin
                    want = expected_matrices.pop_front();
                    for (int k = 0; k < 9; k++)
                        if (got.e[k] !== want.e[k])
                            report_mismatch($sformatf("r%0d%0d got %0d want %0d",
                                            k / 3, k % 3, got.e[k], want.e[k]));
                end
            end
        end
    end
endmodule

/* sim/tb_euler_to_rotation_matrix_core.sv */
// Testbench top for the Euler-angle to rotation-matrix core: drives pose
// requests and register writes and gives the verdict.
// Depends on e2r_pkg, e2r_if, the core RTL and e2r_tb_checker.
module tb_euler_to_rotation_matrix_core import e2r_pkg::*; ;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PIPE_CYCLES = 40;
    localparam int IDLE_LIMIT  = 2000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic [2:0]  cur_order = ORD_XYZ;
    logic        cur_radians = 1'b1;
    int          fail_count, matrix_count, pending;
    int          send_idle_pct = 0, recv_stall_pct = 0;
    int          requests_sent = 0;
    int          quiet_cycles = 0;
    logic        stimulus_done = 1'b0;

    e2r_in_if  pose ();
    e2r_out_if mat ();

    euler_to_rotation_matrix_core u_top (
        .i_clk, .i_rst_n, .i_pose(pose.sink), .o_mat(mat.source),
        .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
    );

    e2r_tb_checker u_checker (
        .i_clk, .i_rst_n, .i_order(cur_order), .i_radians(cur_radians),
        .pose, .mat, .o_fail_count(fail_count), .o_matrix_count(matrix_count),
        .o_pending(pending)
    );

    always #4 i_clk = ~i_clk;

    initial begin
        pose.valid = 1'b0;
        pose.angle_x = '0; pose.angle_y = '0; pose.angle_z = '0;
        mat.ready = 1'b0;
    end

    // Receiver stalls at the configured rate.
    always @(negedge i_clk)
        mat.ready <= ($urandom_range(99) >= recv_stall_pct);

    // Watchdog on cycles with no handshake at all.
    always @(posedge i_clk) begin
        if ((pose.valid && pose.ready) || (mat.valid && mat.ready) || !i_rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT && !stimulus_done) begin
            $display("watchdog: no progress in %0d cycles", IDLE_LIMIT);
            $display("tb_euler_to_rotation_matrix_core: done, errors");
            $finish;
        end
    end

    // Register write: setup cycle then access cycle.
    task automatic write_register(input logic idx, input logic [31:0] value);
        @(negedge i_clk);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= {idx, 2'b00}; pwdata <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (idx == REG_ORDER) cur_order <= value[2:0];
        else cur_radians <= value[0];
        @(negedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    // One pose request, held until accepted.
    task automatic send_pose(input t_angle ax, input t_angle ay, input t_angle az);
        while ($urandom_range(99) < send_idle_pct) begin
            pose.valid <= 1'b0;
            @(negedge i_clk);
        end
        pose.valid <= 1'b1;
        pose.angle_x <= ax; pose.angle_y <= ay; pose.angle_z <= az;
        @(posedge i_clk);
        while (!pose.ready) @(posedge i_clk);
        requests_sent++;
        @(negedge i_clk);
    endtask

    task automatic drain();
        pose.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (PIPE_CYCLES + 5) @(negedge i_clk);
    endtask

    // Random angle, biased toward the extremes and toward small magnitudes.
    function automatic t_angle pick_angle();
        case ($urandom_range(9))
            0: return t_angle'(1) << (ANGLE_BITS - 1);
            1: return ~(t_angle'(1) << (ANGLE_BITS - 1));
            2: return t_angle'(int'($urandom_range(15)) - 8);
            3: return t_angle'(int'($urandom_range(200000)) - 100000);
            default: return t_angle'($urandom);
        endcase
    endfunction

    task automatic random_burst(input int count);
        for (int n = 0; n < count; n++)
            send_pose(pick_angle(), pick_angle(), pick_angle());
    endtask

    localparam t_angle MAX_A = {1'b0, {(ANGLE_BITS-1){1'b1}}};
    localparam t_angle MIN_A = {1'b1, {(ANGLE_BITS-1){1'b0}}};
    // Quarter turn in radians Q3.20 and 90 degrees in Q9.14.
    localparam t_angle HALF_PI = 24'd1647099;
    localparam t_angle DEG90   = 24'd90 << 14;

    initial begin
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: zero, extremes, quarter turns, every order.
        send_pose('0, '0, '0);
        send_pose(MAX_A, MAX_A, MAX_A);
        send_pose(MIN_A, MIN_A, MIN_A);
        send_pose(HALF_PI, -HALF_PI, HALF_PI);
        send_pose(24'hFFFFFF, 24'd1, 24'hAAAAAA);
        drain();
        for (int o = 0; o < 8; o++) begin
            write_register(REG_ORDER, 32'(o) | 32'hFFFF_FFF8);
            send_pose(HALF_PI, 24'd300000, -24'd700000);
            drain();
        end
        write_register(REG_RADIANS, 32'hFFFF_FFFE);
        send_pose(DEG90, -DEG90, 24'd180 << 14);
        send_pose(MAX_A, MIN_A, '0);
        send_pose(24'd45 << 14, 24'd30 << 14, 24'd60 << 14);
        drain();

        // Random phases across settings and idling patterns.
        for (int ph = 0; ph < 12; ph++) begin
            write_register(REG_ORDER, $urandom_range(7));
            write_register(REG_RADIANS, $urandom_range(1));
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 71; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 71; end
                default: begin send_idle_pct = 11; recv_stall_pct = 11; end
            endcase
            random_burst(60);
            drain();
        end

        stimulus_done = 1'b1;
        $display("Sent %0d pose requests over all six orders, both angle units and",
                 requests_sent);
        $display("four idling patterns; %0d matrices checked.", matrix_count);
        if (fail_count == 0 && pending == 0)
            $display("tb_euler_to_rotation_matrix_core: done, clean");
        else
            $display("tb_euler_to_rotation_matrix_core: done, errors");
        $finish;
    end
endmodule

/* filelist.f */
+incdir+hdl
hdl/e2r_pkg.sv
hdl/e2r_if.sv
hdl/e2r_phase.sv
hdl/e2r_cordic.sv
hdl/e2r_matmul.sv
hdl/euler_to_rotation_matrix_core.sv
sim/e2r_tb_checker.sv
sim/tb_euler_to_rotation_matrix_core.sv
